[sv/cpt_pkg.sv]
package cpt_pkg;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int COORD_W = 24;
  localparam int DIFF_W = COORD_W + 1;
  localparam int DOT_W = 2 * DIFF_W + 1;
  localparam int LO_W = 26;
  localparam int HI_W = DOT_W - LO_W;
  localparam int PROD_W = 2 * DOT_W;
  localparam int DIV_W = PROD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [DOT_W-1:0] dot_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DIV_W-1:0] div_t;
  typedef coord_t [2:0] vec24_t;
  typedef diff_t [2:0] vec25_t;

  typedef enum logic [2:0] {
    RGN_VTX_A    = 3'd0,
    RGN_VTX_B    = 3'd1,
    RGN_EDGE_AB  = 3'd2,
    RGN_VTX_C    = 3'd3,
    RGN_EDGE_AC  = 3'd4,
    RGN_EDGE_BC  = 3'd5,
    RGN_INTERIOR = 3'd6
  } region_t;

  typedef struct packed {
    vec24_t a;
    vec24_t b;
    vec24_t c;
    vec25_t ab;
    vec25_t ac;
    vec25_t bc;
    dot_t [5:0] d;
  } geom_t;

  typedef struct packed {
    vec24_t base;
    vec25_t delta0;
    vec25_t delta1;
    region_t region;
    logic degen;
  } side_t;

  typedef struct packed {
    side_t side;
    div_t num0;
    div_t den0;
    div_t num1;
    div_t den1;
  } sel_t;

  function automatic logic le0(div_t x);
    return x[DIV_W-1] || (x == '0);
  endfunction

endpackage

[sv/cpt_ifs.sv]
interface cpt_in_if;
  logic valid;
  logic ready;
  logic signed [23:0] query_x;
  logic signed [23:0] query_y;
  logic signed [23:0] query_z;
  logic signed [23:0] corner_a_x;
  logic signed [23:0] corner_a_y;
  logic signed [23:0] corner_a_z;
  logic signed [23:0] corner_b_x;
  logic signed [23:0] corner_b_y;
  logic signed [23:0] corner_b_z;
  logic signed [23:0] corner_c_x;
  logic signed [23:0] corner_c_y;
  logic signed [23:0] corner_c_z;

  modport source (
    output valid, query_x, query_y, query_z, corner_a_x, corner_a_y, corner_a_z,
    corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
    input ready
  );
  modport sink (
    input valid, query_x, query_y, query_z, corner_a_x, corner_a_y, corner_a_z,
    corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
    output ready
  );
endinterface

interface cpt_out_if #(parameter int WF = cpt_pkg::WEIGHT_FRAC_BITS);
  logic valid;
  logic ready;
  logic signed [23:0] nearest_x;
  logic signed [23:0] nearest_y;
  logic signed [23:0] nearest_z;
  logic [WF:0] weight_a;
  logic [WF:0] weight_b;
  logic [WF:0] weight_c;
  logic [2:0] region;
  logic degenerate;

  modport source (
    output valid, nearest_x, nearest_y, nearest_z, weight_a, weight_b, weight_c,
    region, degenerate,
    input ready
  );
  modport sink (
    input valid, nearest_x, nearest_y, nearest_z, weight_a, weight_b, weight_c,
    region, degenerate,
    output ready
  );
endinterface

[sv/cpt_dot.sv]
module cpt_dot (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  cpt_pkg::vec24_t p,
  input  cpt_pkg::vec24_t a,
  input  cpt_pkg::vec24_t b,
  input  cpt_pkg::vec24_t c,
  output logic out_vld,
  output cpt_pkg::geom_t geom
);

  logic [2:0] vld_r;
  cpt_pkg::vec24_t a1, b1, c1, a2, b2, c2;
  cpt_pkg::vec25_t ab1, ac1, bc1, ap1, bp1, cp1, ab2, ac2, bc2;
  cpt_pkg::vec25_t edge_v [2];
  cpt_pkg::vec25_t pt_v [3];
  logic signed [2*cpt_pkg::DIFF_W-1:0] pr2 [6][3];

  assign edge_v[0] = ab1;
  assign edge_v[1] = ac1;
  assign pt_v[0] = ap1;
  assign pt_v[1] = bp1;
  assign pt_v[2] = cp1;
  assign out_vld = vld_r[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ab1[k] <= cpt_pkg::diff_t'($signed(b[k])) - cpt_pkg::diff_t'($signed(a[k]));
        ac1[k] <= cpt_pkg::diff_t'($signed(c[k])) - cpt_pkg::diff_t'($signed(a[k]));
        bc1[k] <= cpt_pkg::diff_t'($signed(c[k])) - cpt_pkg::diff_t'($signed(b[k]));
        ap1[k] <= cpt_pkg::diff_t'($signed(p[k])) - cpt_pkg::diff_t'($signed(a[k]));
        bp1[k] <= cpt_pkg::diff_t'($signed(p[k])) - cpt_pkg::diff_t'($signed(b[k]));
        cp1[k] <= cpt_pkg::diff_t'($signed(p[k])) - cpt_pkg::diff_t'($signed(c[k]));
      end
      a1 <= a;
      b1 <= b;
      c1 <= c;
      for (int j = 0; j < 6; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr2[j][k] <= $signed(edge_v[j%2][k]) * $signed(pt_v[j/2][k]);
        end
      end
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;
      ab2 <= ab1;
      ac2 <= ac1;
      bc2 <= bc1;
      for (int j = 0; j < 6; j++) begin
        geom.d[j] <= cpt_pkg::dot_t'(pr2[j][0]) + cpt_pkg::dot_t'(pr2[j][1])
                   + cpt_pkg::dot_t'(pr2[j][2]);
      end
      geom.a <= a2;
      geom.b <= b2;
      geom.c <= c2;
      geom.ab <= ab2;
      geom.ac <= ac2;
      geom.bc <= bc2;
    end
  end

endmodule

[sv/cpt_cross.sv]
module cpt_cross (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  cpt_pkg::geom_t geom,
  output logic out_vld,
  output cpt_pkg::sel_t sel
);

  localparam int LW = cpt_pkg::LO_W;
  localparam int HW = cpt_pkg::HI_W;
  localparam int DW = cpt_pkg::DOT_W;

  logic [3:0] vld_r;
  cpt_pkg::geom_t g1, g2, g3;
  cpt_pkg::dot_t op_x [6];
  cpt_pkg::dot_t op_y [6];
  logic signed [2*HW-1:0] hh1 [6];
  logic signed [HW+LW:0] hl1 [6];
  logic signed [HW+LW:0] lh1 [6];
  logic [2*LW-1:0] ll1 [6];
  cpt_pkg::prod_t pp2 [6];
  cpt_pkg::prod_t va3, vb3, vc3;
  logic signed [DW:0] e_ab3, e_ac3, e_bcn3, e_bcm3;
  cpt_pkg::div_t den_c;
  cpt_pkg::sel_t sel_c;

  assign op_x[0] = geom.d[0];
  assign op_y[0] = geom.d[3];
  assign op_x[1] = geom.d[2];
  assign op_y[1] = geom.d[1];
  assign op_x[2] = geom.d[4];
  assign op_y[2] = geom.d[1];
  assign op_x[3] = geom.d[0];
  assign op_y[3] = geom.d[5];
  assign op_x[4] = geom.d[2];
  assign op_y[4] = geom.d[5];
  assign op_x[5] = geom.d[4];
  assign op_y[5] = geom.d[3];
  assign out_vld = vld_r[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        hh1[i] <= $signed(op_x[i][DW-1:LW]) * $signed(op_y[i][DW-1:LW]);
        hl1[i] <= $signed(op_x[i][DW-1:LW]) * $signed({1'b0, op_y[i][LW-1:0]});
        lh1[i] <= $signed({1'b0, op_x[i][LW-1:0]}) * $signed(op_y[i][DW-1:LW]);
        ll1[i] <= op_x[i][LW-1:0] * op_y[i][LW-1:0];
      end
      g1 <= geom;
      for (int i = 0; i < 6; i++) begin
        pp2[i] <= (cpt_pkg::prod_t'(hh1[i]) <<< (2 * LW))
                + (cpt_pkg::prod_t'(hl1[i]) <<< LW)
                + (cpt_pkg::prod_t'(lh1[i]) <<< LW)
                + cpt_pkg::prod_t'(ll1[i]);
      end
      g2 <= g1;
      vc3 <= pp2[0] - pp2[1];
      vb3 <= pp2[2] - pp2[3];
      va3 <= pp2[4] - pp2[5];
      e_ab3 <= (DW+1)'(g2.d[0]) - (DW+1)'(g2.d[2]);
      e_ac3 <= (DW+1)'(g2.d[1]) - (DW+1)'(g2.d[5]);
      e_bcn3 <= (DW+1)'(g2.d[3]) - (DW+1)'(g2.d[2]);
      e_bcm3 <= (DW+1)'(g2.d[4]) - (DW+1)'(g2.d[5]);
      g3 <= g2;
      sel <= sel_c;
    end
  end

  always_comb begin
    den_c = cpt_pkg::div_t'(va3) + cpt_pkg::div_t'(vb3) + cpt_pkg::div_t'(vc3);
    sel_c.side.base = g3.a;
    sel_c.side.delta0 = g3.ab;
    sel_c.side.delta1 = g3.ac;
    sel_c.side.region = cpt_pkg::RGN_VTX_A;
    sel_c.side.degen = 1'b0;
    sel_c.num0 = '0;
    sel_c.den0 = '0;
    sel_c.num1 = '0;
    sel_c.den1 = '0;
    priority if (cpt_pkg::le0(cpt_pkg::div_t'(g3.d[0]))
                 && cpt_pkg::le0(cpt_pkg::div_t'(g3.d[1]))) begin
      sel_c.side.region = cpt_pkg::RGN_VTX_A;
    end else if (!g3.d[2][DW-1] && cpt_pkg::le0(cpt_pkg::div_t'(e_bcn3))) begin
      sel_c.side.base = g3.b;
      sel_c.side.region = cpt_pkg::RGN_VTX_B;
    end else if (cpt_pkg::le0(cpt_pkg::div_t'(vc3)) && !g3.d[0][DW-1]
                 && cpt_pkg::le0(cpt_pkg::div_t'(g3.d[2]))) begin
      sel_c.side.region = cpt_pkg::RGN_EDGE_AB;
      sel_c.num0 = cpt_pkg::div_t'(g3.d[0]);
      sel_c.den0 = cpt_pkg::div_t'(e_ab3);
    end else if (!g3.d[5][DW-1] && cpt_pkg::le0(cpt_pkg::div_t'(e_bcm3))) begin
      sel_c.side.base = g3.c;
      sel_c.side.region = cpt_pkg::RGN_VTX_C;
    end else if (cpt_pkg::le0(cpt_pkg::div_t'(vb3)) && !g3.d[1][DW-1]
                 && cpt_pkg::le0(cpt_pkg::div_t'(g3.d[5]))) begin
      sel_c.side.delta0 = g3.ac;
      sel_c.side.region = cpt_pkg::RGN_EDGE_AC;
      sel_c.num0 = cpt_pkg::div_t'(g3.d[1]);
      sel_c.den0 = cpt_pkg::div_t'(e_ac3);
    end else if (cpt_pkg::le0(cpt_pkg::div_t'(va3)) && !e_bcn3[DW]
                 && !e_bcm3[DW]) begin
      sel_c.side.base = g3.b;
      sel_c.side.delta0 = g3.bc;
      sel_c.side.region = cpt_pkg::RGN_EDGE_BC;
      sel_c.num0 = cpt_pkg::div_t'(e_bcn3);
      sel_c.den0 = cpt_pkg::div_t'(e_bcn3) + cpt_pkg::div_t'(e_bcm3);
    end else if (den_c == '0) begin
      sel_c.side.degen = 1'b1;
    end else begin
      sel_c.side.region = cpt_pkg::RGN_INTERIOR;
      sel_c.num0 = cpt_pkg::div_t'(vb3);
      sel_c.den0 = den_c;
      sel_c.num1 = cpt_pkg::div_t'(vc3);
      sel_c.den1 = den_c;
    end
  end

endmodule

[sv/cpt_div.sv]
module cpt_div #(
  parameter int WF = cpt_pkg::WEIGHT_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  cpt_pkg::sel_t sel,
  output logic out_vld,
  output cpt_pkg::side_t side,
  output logic [WF:0] q0,
  output logic [WF:0] q1
);

  localparam int NS = WF + 2;
  localparam int DW = cpt_pkg::DIV_W;
  localparam logic [WF:0] ONE = (WF+1)'(1) << WF;

  logic [NS-1:0] vld_r;
  cpt_pkg::side_t side_r [NS];
  logic zero_r [2][NS];
  logic one_r [2][NS];
  logic [DW:0] rem_r [2][NS];
  logic [DW-1:0] dv_r [2][NS];
  logic [WF-1:0] q_r [2][NS];
  cpt_pkg::div_t num_c [2];
  cpt_pkg::div_t den_c [2];
  logic zero_c [2];
  logic [DW-1:0] nmag_c [2];
  logic [DW-1:0] dmag_c [2];
  logic [DW:0] sh_c [2][NS];
  logic ge_c [2][NS];
  logic [DW:0] rem_nx [2][NS];
  logic [WF:0] q_o [2];

  assign num_c[0] = sel.num0;
  assign den_c[0] = sel.den0;
  assign num_c[1] = sel.num1;
  assign den_c[1] = sel.den1;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      zero_c[i] = (num_c[i] == '0) || (den_c[i] == '0)
                  || (num_c[i][DW-1] != den_c[i][DW-1]);
      nmag_c[i] = num_c[i][DW-1] ? DW'(-num_c[i]) : DW'(num_c[i]);
      dmag_c[i] = den_c[i][DW-1] ? DW'(-den_c[i]) : DW'(den_c[i]);
      for (int s = 0; s < NS; s++) begin
        sh_c[i][s] = {rem_r[i][s][DW-1:0], 1'b0};
        ge_c[i][s] = sh_c[i][s] >= {1'b0, dv_r[i][s]};
        rem_nx[i][s] = ge_c[i][s] ? sh_c[i][s] - {1'b0, dv_r[i][s]} : sh_c[i][s];
      end
      q_o[i] = zero_r[i][NS-1] ? '0
             : (one_r[i][NS-1] ? ONE : {1'b0, q_r[i][NS-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= sel.side;
      for (int s = 1; s < NS; s++) begin
        side_r[s] <= side_r[s-1];
      end
      for (int i = 0; i < 2; i++) begin
        zero_r[i][0] <= zero_c[i];
        one_r[i][0] <= 1'b0;
        rem_r[i][0] <= {1'b0, nmag_c[i]};
        dv_r[i][0] <= dmag_c[i];
        q_r[i][0] <= '0;
        zero_r[i][1] <= zero_r[i][0];
        one_r[i][1] <= rem_r[i][0] >= {1'b0, dv_r[i][0]};
        rem_r[i][1] <= rem_r[i][0];
        dv_r[i][1] <= dv_r[i][0];
        q_r[i][1] <= q_r[i][0];
        for (int s = 2; s < NS; s++) begin
          zero_r[i][s] <= zero_r[i][s-1];
          one_r[i][s] <= one_r[i][s-1];
          dv_r[i][s] <= dv_r[i][s-1];
          rem_r[i][s] <= rem_nx[i][s-1];
          q_r[i][s] <= {q_r[i][s-1][WF-2:0], ge_c[i][s-1]};
        end
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign side = side_r[NS-1];
  assign q0 = q_o[0];
  assign q1 = q_o[1];

endmodule

[sv/cpt_point.sv]
module cpt_point #(
  parameter int WF = cpt_pkg::WEIGHT_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  cpt_pkg::side_t side,
  input  logic [WF:0] q0,
  input  logic [WF:0] q1,
  cpt_out_if.source result
);

  localparam int PW = cpt_pkg::DIFF_W + WF + 2;
  localparam int SW = cpt_pkg::COORD_W + 3;
  localparam logic [WF:0] ONE = (WF+1)'(1) << WF;
  localparam logic signed [PW-1:0] RND = PW'((64'(1) << WF) - 64'(1));
  localparam logic signed [SW-1:0] CMAX = SW'((64'(1) << (cpt_pkg::COORD_W - 1)) - 64'(1));
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

  logic vld1;
  logic signed [PW-1:0] pr0_r [3];
  logic signed [PW-1:0] pr1_r [3];
  cpt_pkg::vec24_t base_r;
  cpt_pkg::region_t region_r;
  logic degen_r;
  logic [WF:0] wa_c, wb_c, wc_c, wa_r, wb_r, wc_r;
  logic [WF+1:0] qs_c;
  logic signed [PW-1:0] adj0_c [3];
  logic signed [PW-1:0] adj1_c [3];
  logic signed [SW-1:0] sum_c [3];
  logic signed [cpt_pkg::COORD_W-1:0] res_c [3];

  always_comb begin
    qs_c = {1'b0, q0} + {1'b0, q1};
    wa_c = '0;
    wb_c = '0;
    wc_c = '0;
    unique case (side.region)
      cpt_pkg::RGN_VTX_A: wa_c = ONE;
      cpt_pkg::RGN_VTX_B: wb_c = ONE;
      cpt_pkg::RGN_VTX_C: wc_c = ONE;
      cpt_pkg::RGN_EDGE_AB: begin
        wa_c = ONE - q0;
        wb_c = q0;
      end
      cpt_pkg::RGN_EDGE_AC: begin
        wa_c = ONE - q0;
        wc_c = q0;
      end
      cpt_pkg::RGN_EDGE_BC: begin
        wb_c = ONE - q0;
        wc_c = q0;
      end
      cpt_pkg::RGN_INTERIOR: begin
        wb_c = q0;
        wc_c = q1;
        wa_c = (qs_c >= {1'b0, ONE}) ? '0 : ONE - q0 - q1;
      end
      default: begin
        wa_c = '0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      adj0_c[k] = pr0_r[k] + (pr0_r[k][PW-1] ? RND : '0);
      adj1_c[k] = pr1_r[k] + (pr1_r[k][PW-1] ? RND : '0);
      sum_c[k] = SW'($signed(base_r[k])) + SW'(adj0_c[k] >>> WF) + SW'(adj1_c[k] >>> WF);
      if (sum_c[k] > CMAX) begin
        res_c[k] = cpt_pkg::COORD_W'(CMAX);
      end else if (sum_c[k] < CMIN) begin
        res_c[k] = cpt_pkg::COORD_W'(CMIN);
      end else begin
        res_c[k] = cpt_pkg::COORD_W'(sum_c[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      result.valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr0_r[k] <= $signed(side.delta0[k]) * $signed({1'b0, q0});
        pr1_r[k] <= $signed(side.delta1[k]) * $signed({1'b0, q1});
      end
      base_r <= side.base;
      region_r <= side.region;
      degen_r <= side.degen;
      wa_r <= wa_c;
      wb_r <= wb_c;
      wc_r <= wc_c;
      result.nearest_x <= res_c[0];
      result.nearest_y <= res_c[1];
      result.nearest_z <= res_c[2];
      result.weight_a <= wa_r;
      result.weight_b <= wb_r;
      result.weight_c <= wc_r;
      result.region <= region_r;
      result.degenerate <= degen_r;
    end
  end

endmodule

[sv/closest_point_on_triangle_top.sv]
// Closest point on a triangle with barycentric weights, one query per clock
// while no result is held waiting. Queries pass through the dot products, the
// split wide cross products and region select, the restoring divider pipeline
// and the weighted sum. All stages advance together on one enable, held only
// while a result waits.
module closest_point_on_triangle_top #(
  parameter int WEIGHT_FRAC_BITS = cpt_pkg::WEIGHT_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  cpt_in_if.sink query,
  cpt_out_if.source result
);

  localparam logic [WEIGHT_FRAC_BITS:0] ONE = (WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS;

  logic en;
  logic dot_vld, cross_vld, div_vld;
  cpt_pkg::vec24_t p, a, b, c;
  cpt_pkg::geom_t geom;
  cpt_pkg::sel_t sel;
  cpt_pkg::side_t side;
  logic [WEIGHT_FRAC_BITS:0] q0, q1;

  assign en = !result.valid || result.ready;
  assign query.ready = en;
  assign p = {query.query_z, query.query_y, query.query_x};
  assign a = {query.corner_a_z, query.corner_a_y, query.corner_a_x};
  assign b = {query.corner_b_z, query.corner_b_y, query.corner_b_x};
  assign c = {query.corner_c_z, query.corner_c_y, query.corner_c_x};

  cpt_dot u_dot (
    .clk(clk), .rst(rst), .en(en), .in_vld(query.valid),
    .p(p), .a(a), .b(b), .c(c), .out_vld(dot_vld), .geom(geom)
  );

  cpt_cross u_cross (
    .clk(clk), .rst(rst), .en(en), .in_vld(dot_vld), .geom(geom),
    .out_vld(cross_vld), .sel(sel)
  );

  cpt_div #(.WF(WEIGHT_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(cross_vld), .sel(sel),
    .out_vld(div_vld), .side(side), .q0(q0), .q1(q1)
  );

  cpt_point #(.WF(WEIGHT_FRAC_BITS)) u_point (
    .clk(clk), .rst(rst), .en(en), .in_vld(div_vld), .side(side),
    .q0(q0), .q1(q1), .result(result)
  );

`ifndef SYNTHESIS
  a_region_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.region <= cpt_pkg::RGN_INTERIOR)
    else $error("region code out of range");

  a_degen_vertex: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.degenerate) |->
      (result.region == cpt_pkg::RGN_VTX_A && result.weight_a == ONE))
    else $error("degenerate result is not vertex a");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.region != cpt_pkg::RGN_INTERIOR) |->
      ((WEIGHT_FRAC_BITS+3)'(result.weight_a) + (WEIGHT_FRAC_BITS+3)'(result.weight_b)
       + (WEIGHT_FRAC_BITS+3)'(result.weight_c) == (WEIGHT_FRAC_BITS+3)'(ONE)))
    else $error("boundary weights do not sum to one");
`endif

endmodule

[tb/tb_closest_point_on_triangle_top.sv]
`timescale 1ns / 100ps

module tb_closest_point_on_triangle_top;

  localparam int WF = cpt_pkg::WEIGHT_FRAC_BITS;
  localparam logic [WF:0] WEIGHT_ONE = (WF+1)'(1) << WF;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_ITEMS = 200;
  localparam int SQUEEZE_AT = 300;
  localparam int PAUSE_AT = 700;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cpt_pkg::coord_t p[3];
    cpt_pkg::coord_t a[3];
    cpt_pkg::coord_t b[3];
    cpt_pkg::coord_t c[3];
  } tri_query_t;

  typedef struct {
    cpt_pkg::coord_t pos[3];
    logic [WF:0] wa;
    logic [WF:0] wb;
    logic [WF:0] wc;
    cpt_pkg::region_t region;
    logic degen;
  } nearest_t;

  function automatic logic [WF:0] weight_quot(wide_t num, wide_t den);
    logic [127:0] n;
    logic [127:0] d;
    logic [127+WF:0] q;
    if (den == 0 || num == 0 || num[127] != den[127]) return '0;
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    if (n >= d) return WEIGHT_ONE;
    q = {n, WF'(0)} / {WF'(0), d};
    return q[WF:0];
  endfunction

  function automatic longint scale_delta(longint delta, logic [WF:0] wgt);
    longint mag;
    longint prod;
    mag = delta < 0 ? -delta : delta;
    prod = (mag * longint'(wgt)) >>> WF;
    return delta < 0 ? -prod : prod;
  endfunction

  function automatic cpt_pkg::coord_t clamp_coord(longint v);
    if (v > 8388607) return cpt_pkg::coord_t'(8388607);
    if (v < -8388608) return cpt_pkg::coord_t'(-8388608);
    return cpt_pkg::coord_t'(v);
  endfunction

  function automatic longint dot(longint u[3], longint v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic nearest_t predict_nearest(tri_query_t t);
    nearest_t r;
    longint p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
    longint d1, d2, d3, d4, d5, d6;
    wide_t va, vb, vc, den;
    for (int k = 0; k < 3; k++) begin
      p[k] = t.p[k]; a[k] = t.a[k]; b[k] = t.b[k]; c[k] = t.c[k];
      ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
    end
    d1 = dot(ab, ap); d2 = dot(ac, ap); d3 = dot(ab, bp);
    d4 = dot(ac, bp); d5 = dot(ab, cp); d6 = dot(ac, cp);
    r.wa = '0; r.wb = '0; r.wc = '0; r.degen = 1'b0;
    vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
    vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
    va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
    if (d1 <= 0 && d2 <= 0) begin
      r.region = cpt_pkg::RGN_VTX_A; r.wa = WEIGHT_ONE;
      for (int k = 0; k < 3; k++) r.pos[k] = t.a[k];
    end else if (d3 >= 0 && d4 <= d3) begin
      r.region = cpt_pkg::RGN_VTX_B; r.wb = WEIGHT_ONE;
      for (int k = 0; k < 3; k++) r.pos[k] = t.b[k];
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      r.region = cpt_pkg::RGN_EDGE_AB;
      r.wb = weight_quot(wide_t'(d1), wide_t'(d1 - d3));
      r.wa = WEIGHT_ONE - r.wb;
      for (int k = 0; k < 3; k++) r.pos[k] = clamp_coord(a[k] + scale_delta(ab[k], r.wb));
    end else if (d6 >= 0 && d5 <= d6) begin
      r.region = cpt_pkg::RGN_VTX_C; r.wc = WEIGHT_ONE;
      for (int k = 0; k < 3; k++) r.pos[k] = t.c[k];
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      r.region = cpt_pkg::RGN_EDGE_AC;
      r.wc = weight_quot(wide_t'(d2), wide_t'(d2 - d6));
      r.wa = WEIGHT_ONE - r.wc;
      for (int k = 0; k < 3; k++) r.pos[k] = clamp_coord(a[k] + scale_delta(ac[k], r.wc));
    end else if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
      r.region = cpt_pkg::RGN_EDGE_BC;
      r.wc = weight_quot(wide_t'(d4 - d3), wide_t'((d4 - d3) + (d5 - d6)));
      r.wb = WEIGHT_ONE - r.wc;
      for (int k = 0; k < 3; k++) r.pos[k] = clamp_coord(b[k] + scale_delta(bc[k], r.wc));
    end else begin
      den = va + vb + vc;
      if (den == 0) begin
        r.region = cpt_pkg::RGN_VTX_A; r.degen = 1'b1; r.wa = WEIGHT_ONE;
        for (int k = 0; k < 3; k++) r.pos[k] = t.a[k];
      end else begin
        r.region = cpt_pkg::RGN_INTERIOR;
        r.wb = weight_quot(vb, den);
        r.wc = weight_quot(vc, den);
        r.wa = ((WF+2)'(r.wb) + (WF+2)'(r.wc) >= (WF+2)'(WEIGHT_ONE)) ? '0
             : WEIGHT_ONE - r.wb - r.wc;
        for (int k = 0; k < 3; k++)
          r.pos[k] = clamp_coord(a[k] + scale_delta(ab[k], r.wb) + scale_delta(ac[k], r.wc));
      end
    end
    return r;
  endfunction

  class nearest_board;
    nearest_t pending[$];
    int mismatches = 0;

    function void note_query(tri_query_t t);
      pending = {pending, predict_nearest(t)};
    endfunction

    function void check_result(nearest_t got);
      nearest_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer region=%0d", got.region);
        return;
      end
      exp_r = pending.pop_front();
      if (got.pos[0] !== exp_r.pos[0] || got.pos[1] !== exp_r.pos[1] ||
          got.pos[2] !== exp_r.pos[2] || got.wa !== exp_r.wa || got.wb !== exp_r.wb ||
          got.wc !== exp_r.wc || got.region !== exp_r.region || got.degen !== exp_r.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp pos=%0d,%0d,%0d w=%0d,%0d,%0d r=%0d g=%0d",
                   exp_r.pos[0], exp_r.pos[1], exp_r.pos[2], exp_r.wa, exp_r.wb, exp_r.wc,
                   exp_r.region, exp_r.degen,
                   " act pos=%0d,%0d,%0d w=%0d,%0d,%0d r=%0d g=%0d",
                   got.pos[0], got.pos[1], got.pos[2],
                   got.wa, got.wb, got.wc, got.region, got.degen);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  cpt_in_if query_bus();
  cpt_out_if result_bus();
  nearest_board board;
  bit calm = 0;
  bit squeeze = 0;
  int transfers = 0;

  closest_point_on_triangle_top uut (
    .clk(clk),
    .rst(rst),
    .query(query_bus),
    .result(result_bus)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic tri_query_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                            int bx, int by, int bz, int cx, int cy, int cz);
    tri_query_t t;
    t.p[0] = cpt_pkg::coord_t'(px); t.p[1] = cpt_pkg::coord_t'(py);
    t.p[2] = cpt_pkg::coord_t'(pz);
    t.a[0] = cpt_pkg::coord_t'(ax); t.a[1] = cpt_pkg::coord_t'(ay);
    t.a[2] = cpt_pkg::coord_t'(az);
    t.b[0] = cpt_pkg::coord_t'(bx); t.b[1] = cpt_pkg::coord_t'(by);
    t.b[2] = cpt_pkg::coord_t'(bz);
    t.c[0] = cpt_pkg::coord_t'(cx); t.c[1] = cpt_pkg::coord_t'(cy);
    t.c[2] = cpt_pkg::coord_t'(cz);
    return t;
  endfunction

  function automatic cpt_pkg::coord_t near_coord(cpt_pkg::coord_t center, int spread);
    return cpt_pkg::coord_t'(int'(center) + $urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic tri_query_t random_query();
    tri_query_t t;
    cpt_pkg::coord_t ctr[3];
    int spread;
    int kind;
    kind = $urandom_range(0, 9);
    spread = (1 << $urandom_range(2, 16));
    for (int k = 0; k < 3; k++) begin
      ctr[k] = cpt_pkg::coord_t'($urandom());
      if (kind <= 1) begin
        t.p[k] = cpt_pkg::coord_t'($urandom()); t.a[k] = cpt_pkg::coord_t'($urandom());
        t.b[k] = cpt_pkg::coord_t'($urandom()); t.c[k] = cpt_pkg::coord_t'($urandom());
      end else begin
        t.a[k] = near_coord(ctr[k], spread); t.b[k] = near_coord(ctr[k], spread);
        t.c[k] = near_coord(ctr[k], spread); t.p[k] = near_coord(ctr[k], 2 * spread);
      end
    end
    for (int k = 0; k < 3; k++) begin
      case (kind)
        7: t.b[k] = t.a[k];
        8: t.c[k] = t.b[k];
        9: t.c[k] = cpt_pkg::coord_t'(2 * int'(t.b[k]) - int'(t.a[k]));
        default: ;
      endcase
    end
    if ($urandom_range(0, 29) == 0)
      t.a[$urandom_range(0, 2)] = cpt_pkg::coord_t'($urandom_range(0, 1) ? 8388607 : -8388608);
    return t;
  endfunction

  task automatic send_query(tri_query_t t);
    @(negedge clk);
    query_bus.valid <= 1'b1;
    query_bus.query_x <= t.p[0]; query_bus.query_y <= t.p[1]; query_bus.query_z <= t.p[2];
    query_bus.corner_a_x <= t.a[0]; query_bus.corner_a_y <= t.a[1];
    query_bus.corner_a_z <= t.a[2];
    query_bus.corner_b_x <= t.b[0]; query_bus.corner_b_y <= t.b[1];
    query_bus.corner_b_z <= t.b[2];
    query_bus.corner_c_x <= t.c[0]; query_bus.corner_c_y <= t.c[1];
    query_bus.corner_c_z <= t.c[2];
    do @(posedge clk); while (!query_bus.ready);
    board.note_query(t);
  endtask

  task automatic hold_query(int n);
    repeat (n) begin
      @(negedge clk);
      query_bus.valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    query_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    tri_query_t directed[$];
    int one;
    one = 4096;
    board = new();
    rst = 1'b1;
    query_bus.valid = 1'b0;
    query_bus.query_x = '0; query_bus.query_y = '0; query_bus.query_z = '0;
    query_bus.corner_a_x = '0; query_bus.corner_a_y = '0; query_bus.corner_a_z = '0;
    query_bus.corner_b_x = '0; query_bus.corner_b_y = '0; query_bus.corner_b_z = '0;
    query_bus.corner_c_x = '0; query_bus.corner_c_y = '0; query_bus.corner_c_z = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed = {directed, make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(one, one, 0, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0)};
    directed = {directed, make_query(-one, -one, one, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0)};
    directed = {directed, make_query(6 * one, -one, 0, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0)};
    directed = {directed, make_query(2 * one, -one, one, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one,
                                     0)};
    directed = {directed, make_query(-one, 6 * one, 0, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0)};
    directed = {directed, make_query(-one, 2 * one, -one, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one,
                                     0)};
    directed = {directed, make_query(3 * one, 3 * one, 0, 0, 0, 0, 4 * one, 0, 0, 0, 4 * one,
                                     0)};
    directed = {directed, make_query(one, one, 0, one, 0, 0, one, 0, 0, 0, 3 * one, 0)};
    directed = {directed, make_query(one, 5, 7, 0, 0, 0, 4 * one, 0, 0, 4 * one, 0, 0)};
    directed = {directed, make_query(one, one, one, 0, 0, 0, one, one, 0, 2 * one, 2 * one,
                                     0)};
    directed = {directed, make_query(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                                     8388607, -8388608, 0, -8388608, 8388607, 0)};
    directed = {directed, make_query(-8388608, 8388607, -8388608, 8388607, 8388607, 8388607,
                                     -8388608, -8388608, -8388608, 8388607, -8388608,
                                     8388607)};
    directed = {directed, make_query(0, 0, 0, 8388607, -8388608, 0, -8388608, 8388607, 0,
                                     -8388608, -8388608, 8388607)};
    directed = {directed, make_query(-1, -1, -1, 8388607, 8388607, 8388607, 8388607, 8388607,
                                     8388607, 8388607, 8388607, 8388607)};
    directed = {directed, make_query(1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 1, 0)};
    foreach (directed[i]) begin
      send_query(directed[i]);
      if ($urandom_range(0, 2) == 0) hold_query($urandom_range(1, 13));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == SQUEEZE_AT) squeeze = 1;
      if (i == PAUSE_AT) wait_drained();
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1;
      send_query(random_query());
      if (!calm && !squeeze && $urandom_range(0, 3) == 0) hold_query($urandom_range(1, 13));
    end
    hold_query(1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n;
    result_bus.ready = 1'b0;
    forever begin
      if (squeeze) begin
        repeat (400) begin
          @(negedge clk);
          result_bus.ready <= 1'b0;
        end
        squeeze = 0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 13);
        repeat (n) begin
          @(negedge clk);
          result_bus.ready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          @(negedge clk);
          result_bus.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    nearest_t got;
    if (!rst && query_bus.valid && query_bus.ready) transfers++;
    if (!rst && result_bus.valid && result_bus.ready) begin
      transfers++;
      got.pos[0] = result_bus.nearest_x;
      got.pos[1] = result_bus.nearest_y;
      got.pos[2] = result_bus.nearest_z;
      got.wa = result_bus.weight_a;
      got.wb = result_bus.weight_b;
      got.wc = result_bus.weight_c;
      got.region = cpt_pkg::region_t'(result_bus.region);
      got.degen = result_bus.degenerate;
      board.check_result(got);
    end
  end

  initial begin
    int quiet;
    int last;
    quiet = 0;
    last = 0;
    forever begin
      @(posedge clk);
      #1;
      if (transfers != last) begin
        last = transfers;
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

[files.f]
sv/cpt_pkg.sv
sv/cpt_ifs.sv
sv/cpt_dot.sv
sv/cpt_cross.sv
sv/cpt_div.sv
sv/cpt_point.sv
sv/closest_point_on_triangle_top.sv
tb/tb_closest_point_on_triangle_top.sv
